>>> src/pbc_pkg.sv
package pbc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 16;
  localparam int GAIN_W   = 32;
  localparam int LIM_W    = 15;
  localparam int DWELL_W  = 16;
  localparam int DRV_W    = 16;
  localparam int MODE_W   = 2;

  localparam int NUM_REGS = 8;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int ADDR_W   = REG_IDX_W + 2;
  localparam int APB_W    = 32;

  localparam logic [REG_IDX_W-1:0] REG_GAIN_ARM       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_PENDULUM  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_ARM_RATE  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_PEND_RATE = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ENGAGE_ANGLE   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_PENDULUM_LIMIT = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_ARM_LIMIT      = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_DWELL_TICKS    = 3'd7;

  localparam logic signed [GAIN_W-1:0] RST_GAIN_ARM       = -32'sd65536;
  localparam logic signed [GAIN_W-1:0] RST_GAIN_PENDULUM  = 32'sd5387046;
  localparam logic signed [GAIN_W-1:0] RST_GAIN_ARM_RATE  = -32'sd144036332;
  localparam logic signed [GAIN_W-1:0] RST_GAIN_PEND_RATE = 32'sd1021143;
  localparam logic [LIM_W-1:0]   RST_ENGAGE_ANGLE   = 15'd410;
  localparam logic [LIM_W-1:0]   RST_PENDULUM_LIMIT = 15'd1430;
  localparam logic [LIM_W-1:0]   RST_ARM_LIMIT      = 15'd6434;
  localparam logic [DWELL_W-1:0] RST_DWELL_TICKS    = 16'd400;

  localparam logic [MODE_W-1:0] MODE_PASSIVE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SWITCHING = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ACTIVE    = 2'd2;

  localparam int OPND_W  = SAMPLE_W + 1;
  localparam int PROD_W  = OPND_W + GAIN_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int SHIFT   = 20;
  localparam int RES_W   = SUM_W - SHIFT;
  localparam int MAG_W   = (OPND_W > LIM_W) ? OPND_W : LIM_W;
  localparam int CMP_W   = (COUNT_W > DWELL_W) ? COUNT_W : DWELL_W;

  localparam int IN_BITS    = 3 * SAMPLE_W + 3;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = DRV_W + 3 + MODE_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_arm;
    logic signed [GAIN_W-1:0] gain_pendulum;
    logic signed [GAIN_W-1:0] gain_arm_rate;
    logic signed [GAIN_W-1:0] gain_pendulum_rate;
    logic [LIM_W-1:0]         engage_angle;
    logic [LIM_W-1:0]         pendulum_limit;
    logic [LIM_W-1:0]         arm_limit;
    logic [DWELL_W-1:0]       dwell_ticks;
  } cfg_t;

  typedef struct packed {
    logic                     valid;
    logic                     active;
    logic                     calibrate_request;
    logic                     release_motor;
    logic [MODE_W-1:0]        mode;
    logic signed [PROD_W-1:0] p_arm;
    logic signed [PROD_W-1:0] p_pendulum;
    logic signed [PROD_W-1:0] p_arm_rate;
    logic signed [PROD_W-1:0] p_pendulum_rate;
  } stage_t;

endpackage

>>> src/pbc_regs.sv
module pbc_regs
  import pbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]  pwdata,
  output logic [APB_W-1:0]  prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_arm           <= RST_GAIN_ARM;
      cfg.gain_pendulum      <= RST_GAIN_PENDULUM;
      cfg.gain_arm_rate      <= RST_GAIN_ARM_RATE;
      cfg.gain_pendulum_rate <= RST_GAIN_PEND_RATE;
      cfg.engage_angle       <= RST_ENGAGE_ANGLE;
      cfg.pendulum_limit     <= RST_PENDULUM_LIMIT;
      cfg.arm_limit          <= RST_ARM_LIMIT;
      cfg.dwell_ticks        <= RST_DWELL_TICKS;
    end else if (wr_en) begin
      unique case (idx)
        REG_GAIN_ARM:       cfg.gain_arm           <= pwdata[GAIN_W-1:0];
        REG_GAIN_PENDULUM:  cfg.gain_pendulum      <= pwdata[GAIN_W-1:0];
        REG_GAIN_ARM_RATE:  cfg.gain_arm_rate      <= pwdata[GAIN_W-1:0];
        REG_GAIN_PEND_RATE: cfg.gain_pendulum_rate <= pwdata[GAIN_W-1:0];
        REG_ENGAGE_ANGLE:   cfg.engage_angle       <= pwdata[LIM_W-1:0];
        REG_PENDULUM_LIMIT: cfg.pendulum_limit     <= pwdata[LIM_W-1:0];
        REG_ARM_LIMIT:      cfg.arm_limit          <= pwdata[LIM_W-1:0];
        REG_DWELL_TICKS:    cfg.dwell_ticks        <= pwdata[DWELL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAIN_ARM:       prdata = APB_W'(cfg.gain_arm);
      REG_GAIN_PENDULUM:  prdata = APB_W'(cfg.gain_pendulum);
      REG_GAIN_ARM_RATE:  prdata = APB_W'(cfg.gain_arm_rate);
      REG_GAIN_PEND_RATE: prdata = APB_W'(cfg.gain_pendulum_rate);
      REG_ENGAGE_ANGLE:   prdata = {{(APB_W-LIM_W){1'b0}}, cfg.engage_angle};
      REG_PENDULUM_LIMIT: prdata = {{(APB_W-LIM_W){1'b0}}, cfg.pendulum_limit};
      REG_ARM_LIMIT:      prdata = {{(APB_W-LIM_W){1'b0}}, cfg.arm_limit};
      REG_DWELL_TICKS:    prdata = {{(APB_W-DWELL_W){1'b0}}, cfg.dwell_ticks};
      default:            prdata = '0;
    endcase
  end

endmodule

>>> src/pbc_ctrl.sv
module pbc_ctrl
  import pbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  s_tvalid,
  input  logic [IN_TDATA_W-1:0] s_tdata,
  input  cfg_t                  cfg,
  output stage_t                stage
);

  logic                       in_valid;
  logic signed [SAMPLE_W-1:0] arm;
  logic signed [SAMPLE_W-1:0] pend;
  logic signed [SAMPLE_W-1:0] rate;
  logic                       calib_ok;
  logic                       drive_ok;
  logic                       abort_in;

  logic [MODE_W-1:0]   mode;
  logic [MODE_W-1:0]   mode_next;
  logic [COUNT_W-1:0]  dwell_count;
  logic [COUNT_W-1:0]  dwell_count_next;
  logic [SAMPLE_W-1:0] prev_arm;
  logic [SAMPLE_W-1:0] prev_arm_next;

  logic calreq;
  logic release_m;
  logic active;

  logic signed [OPND_W-1:0] arm_x;
  logic signed [OPND_W-1:0] pend_x;
  logic signed [OPND_W-1:0] rate_x;
  logic signed [OPND_W-1:0] prev_x;
  logic signed [OPND_W-1:0] neg_arm;
  logic signed [OPND_W-1:0] diff_arm;
  logic [MAG_W-1:0]         pmag;
  logic [MAG_W-1:0]         amag;
  logic [MAG_W-1:0]         engage_x;
  logic [MAG_W-1:0]         plim_x;
  logic [MAG_W-1:0]         alim_x;

  logic signed [PROD_W-1:0] p_arm;
  logic signed [PROD_W-1:0] p_pend;
  logic signed [PROD_W-1:0] p_arm_rate;
  logic signed [PROD_W-1:0] p_pend_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (adv) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      arm      <= s_tdata[SAMPLE_W-1:0];
      pend     <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
      rate     <= s_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
      calib_ok <= s_tdata[3*SAMPLE_W];
      drive_ok <= s_tdata[3*SAMPLE_W+1];
      abort_in <= s_tdata[3*SAMPLE_W+2];
    end
  end

  assign arm_x    = {arm[SAMPLE_W-1], arm};
  assign pend_x   = {pend[SAMPLE_W-1], pend};
  assign rate_x   = {rate[SAMPLE_W-1], rate};
  assign prev_x   = {prev_arm[SAMPLE_W-1], prev_arm};
  assign neg_arm  = -arm_x;
  assign diff_arm = prev_x - arm_x;

  assign pmag     = MAG_W'(pend_x[OPND_W-1] ? -pend_x : pend_x);
  assign amag     = MAG_W'(arm_x[OPND_W-1] ? neg_arm : arm_x);
  assign engage_x = MAG_W'(cfg.engage_angle);
  assign plim_x   = MAG_W'(cfg.pendulum_limit);
  assign alim_x   = MAG_W'(cfg.arm_limit);

  assign p_arm       = neg_arm * cfg.gain_arm;
  assign p_pend      = pend_x * cfg.gain_pendulum;
  assign p_arm_rate  = diff_arm * cfg.gain_arm_rate;
  assign p_pend_rate = rate_x * cfg.gain_pendulum_rate;

  always_comb begin
    mode_next        = mode;
    dwell_count_next = dwell_count;
    prev_arm_next    = prev_arm;
    calreq           = 1'b0;
    release_m        = 1'b0;
    active           = 1'b0;
    priority if (abort_in) begin
      mode_next = MODE_PASSIVE;
      release_m = 1'b1;
    end else begin
      unique case (mode)
        MODE_SWITCHING: begin
          if (CMP_W'(dwell_count) >= CMP_W'(cfg.dwell_ticks)) begin
            calreq = 1'b1;
            if (calib_ok) begin
              prev_arm_next = '0;
              mode_next     = MODE_ACTIVE;
            end else begin
              mode_next = MODE_PASSIVE;
            end
          end
          if (pmag > engage_x) begin
            mode_next = MODE_PASSIVE;
          end
          dwell_count_next = dwell_count + 1'b1;
        end
        MODE_ACTIVE: begin
          active        = 1'b1;
          prev_arm_next = arm;
          if (!drive_ok || pmag > plim_x || amag > alim_x) begin
            release_m = 1'b1;
            mode_next = MODE_PASSIVE;
          end
        end
        default: begin
          mode_next = MODE_PASSIVE;
          if (pmag < engage_x) begin
            mode_next        = MODE_SWITCHING;
            dwell_count_next = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_PASSIVE;
      dwell_count <= '0;
      prev_arm    <= '0;
    end else if (adv && in_valid) begin
      mode        <= mode_next;
      dwell_count <= dwell_count_next;
      prev_arm    <= prev_arm_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (adv) begin
      stage.valid <= in_valid;
    end
    if (adv) begin
      stage.active            <= active;
      stage.calibrate_request <= calreq;
      stage.release_motor     <= release_m;
      stage.mode              <= mode_next;
      stage.p_arm             <= p_arm;
      stage.p_pendulum        <= p_pend;
      stage.p_arm_rate        <= p_arm_rate;
      stage.p_pendulum_rate   <= p_pend_rate;
    end
  end

endmodule

>>> src/pbc_drive.sv
module pbc_drive
  import pbc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  stage_t                 stage,
  output logic                   m_tvalid,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) <<< (SHIFT - 1);

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] sum_sh;
  logic [RES_W-1:0]        res;
  logic [RES_W-DRV_W:0]    res_hi;
  logic [DRV_W-1:0]        sat;
  logic [DRV_W-1:0]        drive;

  assign sum = SUM_W'($signed(stage.p_arm)) + SUM_W'($signed(stage.p_pendulum))
             + SUM_W'($signed(stage.p_arm_rate)) + SUM_W'($signed(stage.p_pendulum_rate))
             + ROUND_BIAS;
  assign sum_sh = sum >>> SHIFT;
  assign res    = sum_sh[RES_W-1:0];
  assign res_hi = res[RES_W-1:DRV_W-1];

  always_comb begin
    priority if (res_hi == '0 || res_hi == '1) begin
      sat = res[DRV_W-1:0];
    end else if (res[RES_W-1]) begin
      sat = {1'b1, {(DRV_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(DRV_W-1){1'b1}}};
    end
  end

  assign drive = stage.active ? sat : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= OUT_TDATA_W'({stage.mode, stage.release_motor,
                               stage.calibrate_request, stage.active, drive});
    end
  end

endmodule

>>> src/pendulum_balance_controller.sv
// An accepted input moves through the input, product and result registers to m_tvalid.
// Throughput: one transaction per cycle; input register, product register and
// result register advance together, so the rate is set by m_tready alone.
// Reset (rst, synchronous): passive mode, dwell count and previous arm cleared,
// pipeline emptied, configuration registers back to their defaults.
module pendulum_balance_controller
  import pbc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // arm_angle, pendulum_angle, pendulum_rate, calib_ok, drive_ok, abort
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // drive_value, drive_valid, calibrate_request, release_motor, mode
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [APB_W-1:0]       pwdata,
  output logic [APB_W-1:0]       prdata,
  output logic                   pready
);

  cfg_t   cfg;
  stage_t stage;
  logic   adv;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  pbc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .s_tvalid (s_tvalid),
    .s_tdata  (s_tdata),
    .cfg      (cfg),
    .stage    (stage)
  );

  pbc_drive u_drive (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .stage    (stage),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
  );

endmodule

>>> src/pbc_checker.sv
module pbc_checker
  import pbc_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  logic [DRV_W-1:0]  drive_value;
  logic              drive_valid;
  logic              calreq;
  logic              release_m;
  logic [MODE_W-1:0] mode;

  assign drive_value = m_tdata[DRV_W-1:0];
  assign drive_valid = m_tdata[DRV_W];
  assign calreq      = m_tdata[DRV_W+1];
  assign release_m   = m_tdata[DRV_W+2];
  assign mode        = m_tdata[DRV_W+4:DRV_W+3];

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  a_drive_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !drive_valid |-> drive_value == '0)
    else $error("drive value without drive valid");

  a_release_passive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && release_m |-> mode == MODE_PASSIVE && !calreq)
    else $error("release without passive mode");

  a_drive_mode: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && drive_valid |-> !calreq && mode != MODE_SWITCHING)
    else $error("drive issued outside active control");

endmodule

bind pendulum_balance_controller pbc_checker u_pbc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
